// File: rtl/mbs_pkg.sv
`default_nettype none
package mbs_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    // count width: holds 0..CAPACITY
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FIELD_W  = 7;
    localparam int CMP_W    = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
    localparam logic [FIELD_W-1:0] SAT_MAX = 7'd127;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_COUNT  = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    // no operation: contents untouched, only size reported
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic              shift;    // shift the prefix [0, len) toward the head
        logic [CNT_W-1:0]  len;      // live prefix length
        logic              keep;     // head beat re-enters at len-1
        logic              wr_en;    // direct write of one cell
        logic [CNT_W-1:0]  wr_idx;
        logic [DATA_W-1:0] wr_data;
    } t_cell_ctl;

    function automatic logic [FIELD_W-1:0] sat7(input logic [CNT_W-1:0] v);
        logic [CMP_W-1:0] x;
        x = CMP_W'(v);
        return (x > CMP_W'(SAT_MAX)) ? SAT_MAX : x[FIELD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/multiset_bag_store.sv
// Sequence: count and insert run the count pass only; remove runs the count pass and
//   then the compaction pass; an unused action code runs neither. Each pass steps the
//   cell chain once per stored entry, one entry per cycle, and a new beat is taken only
//   after the reply of the last one is loaded (o_in_stall is high meanwhile).
// Reset: synchronous, active low; clears fill, state and output valid. Cell contents
//   are not reset and are only read below fill.
`default_nettype none
module multiset_bag_store
    import mbs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_action,
    input  wire logic [DATA_W-1:0]  i_value,
    input  wire logic [FIELD_W-1:0] i_limit,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_found,
    output logic      [FIELD_W-1:0] o_occurrences,
    output logic      [FIELD_W-1:0] o_removed,
    output logic      [FIELD_W-1:0] o_size,
    output logic                    o_empty_res,
    output logic                    o_rejected
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_COUNT  = 3'd1;
    localparam logic [2:0] S_POST   = 3'd2;
    localparam logic [2:0] S_REMOVE = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    // control
    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_fill,  n_fill;
    logic [CNT_W-1:0]   r_i,     n_i;
    logic               r_out_valid, n_out_valid;

    // working registers for the beat in flight
    logic [1:0]         r_act;
    logic [DATA_W-1:0]  r_value;
    logic [FIELD_W-1:0] r_limit;
    logic [CNT_W-1:0]   r_occ,  n_occ;
    logic [CNT_W-1:0]   r_rem,  n_rem;
    logic [CNT_W-1:0]   r_keep, n_keep;
    logic [CNT_W-1:0]   r_seen, n_seen;
    logic [CNT_W-1:0]   r_len,  n_len;
    logic               r_rej,  n_rej;

    // output payload
    logic               r_found;
    logic [FIELD_W-1:0] r_occ_o, r_rem_o, r_size_o;
    logic               r_empty_o, r_rej_o;

    t_cell_ctl          ctl;
    logic [DATA_W-1:0]  head;
    logic               match;
    logic               drop;
    logic               last;
    logic               accept;
    logic               load_out;
    logic [CMP_W-1:0]   lim_ext, occ_ext;

    mbs_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .o_head (head)
    );

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign match    = (head == r_value);
    // during compaction, copies past the first "keep" ones are dropped (last ones go)
    assign drop     = match && (r_seen >= r_keep);
    assign last     = (r_i == (r_fill - CNT_W'(1)));
    assign load_out = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);
    assign lim_ext  = CMP_W'(r_limit);
    assign occ_ext  = CMP_W'(r_occ);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_i         = r_i;
        n_occ       = r_occ;
        n_rem       = r_rem;
        n_keep      = r_keep;
        n_seen      = r_seen;
        n_len       = r_len;
        n_rej       = r_rej;
        n_out_valid = r_out_valid;

        ctl         = '0;
        ctl.wr_idx  = r_fill;
        ctl.wr_data = r_value;
        ctl.len     = r_fill;
        ctl.keep    = 1'b1;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_i    = '0;
                    n_occ  = '0;
                    n_rem  = '0;
                    n_seen = '0;
                    n_rej  = 1'b0;
                    if (i_action == ACT_UNUSED) begin
                        n_state = S_FINISH;
                    end else if (r_fill == '0) begin
                        n_state = S_POST;
                    end else begin
                        n_state = S_COUNT;
                    end
                end
            end
            S_COUNT: begin
                // rotate the live prefix by one entry; order is restored after a full pass
                ctl.shift = 1'b1;
                if (match) begin
                    n_occ = r_occ + CNT_W'(1);
                end
                n_i = r_i + CNT_W'(1);
                if (last) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                n_i   = '0;
                n_len = r_fill;
                case (r_act)
                    ACT_INSERT: begin
                        if (r_fill == CNT_W'(CAPACITY)) begin
                            n_rej = 1'b1;
                        end else begin
                            ctl.wr_en = 1'b1;
                            n_fill    = r_fill + CNT_W'(1);
                        end
                        n_state = S_FINISH;
                    end
                    ACT_REMOVE: begin
                        n_rem   = (lim_ext < occ_ext) ? CNT_W'(r_limit) : r_occ;
                        n_keep  = r_occ - n_rem;
                        n_state = (r_fill == '0) ? S_FINISH : S_REMOVE;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_REMOVE: begin
                // kept head re-enters at the end of the shrinking prefix
                ctl.shift = 1'b1;
                ctl.len   = r_len;
                ctl.keep  = !drop;
                if (match) begin
                    n_seen = r_seen + CNT_W'(1);
                end
                if (drop) begin
                    n_len = r_len - CNT_W'(1);
                end
                n_i = r_i + CNT_W'(1);
                if (last) begin
                    n_fill  = n_len;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_i         <= n_i;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act   <= i_action;
            r_value <= i_value;
            r_limit <= i_limit;
        end
        r_occ  <= n_occ;
        r_rem  <= n_rem;
        r_keep <= n_keep;
        r_seen <= n_seen;
        r_len  <= n_len;
        r_rej  <= n_rej;
        if (load_out) begin
            r_found   <= (r_occ != '0);
            r_occ_o   <= sat7(r_occ);
            r_rem_o   <= sat7(r_rem);
            r_size_o  <= sat7(r_fill);
            r_empty_o <= (r_fill == '0);
            r_rej_o   <= r_rej;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_occurrences = r_occ_o;
    assign o_removed     = r_rem_o;
    assign o_size        = r_size_o;
    assign o_empty_res   = r_empty_o;
    assign o_rejected    = r_rej_o;

endmodule
`default_nettype wire

// File: rtl/mbs_cell.sv
`default_nettype none
module mbs_cell
    import mbs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [CNT_W-1:0]  i_idx,
    input  wire logic [DATA_W-1:0] i_nbr,
    input  wire logic [DATA_W-1:0] i_head,
    output logic      [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_data;
    logic [CNT_W-1:0]  pos;

    assign pos    = i_idx + CNT_W'(1);
    assign o_data = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && (i_ctl.wr_idx == i_idx)) begin
            r_data <= i_ctl.wr_data;
        end else if (i_ctl.shift) begin
            if (pos < i_ctl.len) begin
                r_data <= i_nbr;
            end else if ((pos == i_ctl.len) && i_ctl.keep) begin
                r_data <= i_head;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/mbs_chain.sv
`default_nettype none
module mbs_chain
    import mbs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    output logic      [DATA_W-1:0] o_head
);

    logic [DATA_W-1:0] data [CAPACITY];

    assign o_head = data[0];

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_W-1:0] nbr;
        if (k == CAPACITY - 1) begin : g_last
            assign nbr = data[0];
        end else begin : g_mid
            assign nbr = data[k+1];
        end
        mbs_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (i_ctl),
            .i_idx  (CNT_W'(k)),
            .i_nbr  (nbr),
            .i_head (data[0]),
            .o_data (data[k])
        );
    end

endmodule
`default_nettype wire

// File: tb/sv/tb_multiset_bag_store.sv
`default_nettype none
module tb_multiset_bag_store;
    import mbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_BEATS = 1100;
    // Worst correct pace per beat is a full idle gap plus a remove on a full store plus a
    // full receiver stall; the timeout allows five times that pace over all ~1150 beats.
    localparam int TIMEOUT_NS   = 1_000_000 * CLK_PERIOD;
    // Receiver hold-off: starts after this many accepted beats, lasts this long.
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [1:0]         action;
        logic [DATA_W-1:0]  value;
        logic [FIELD_W-1:0] limit;
    } t_bag_action;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] occurrences;
        logic [FIELD_W-1:0] removed;
        logic [FIELD_W-1:0] size_now;
        logic               empty_res;
        logic               rejected;
    } t_bag_reply;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_action;
    logic [DATA_W-1:0]  i_value;
    logic [FIELD_W-1:0] i_limit;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_found;
    logic [FIELD_W-1:0] o_occurrences;
    logic [FIELD_W-1:0] o_removed;
    logic [FIELD_W-1:0] o_size;
    logic               o_empty_res;
    logic               o_rejected;

    multiset_bag_store dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_limit       (i_limit),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_occurrences (o_occurrences),
        .o_removed     (o_removed),
        .o_size        (o_size),
        .o_empty_res   (o_empty_res),
        .o_rejected    (o_rejected)
    );

    // Shadow copy of the bag: compacted, insertion order, entries below bag_fill valid.
    logic [DATA_W-1:0] bag_slots [CAPACITY];
    int                bag_fill;

    t_bag_action actions_to_send [$];   // filled up front, drained by the driver
    t_bag_reply  replies_due [$];       // one per accepted beat, oldest first

    int n_accepted;     // input beats taken by the block
    int n_replies;      // output beats taken from the block
    int n_errors;
    logic hold_on;      // long receiver hold-off in progress

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [FIELD_W-1:0] clip7(input int n);
        return (n > 127) ? 7'd127 : FIELD_W'(n);
    endfunction

    // Applies one action to the shadow bag and returns the reply it must produce.
    function automatic t_bag_reply apply_bag_action(input t_bag_action a);
        t_bag_reply r;
        int occ;
        int cut;
        int keep;
        int seen;
        int w;
        r   = '0;
        occ = 0;
        cut = 0;
        // unused code does not even look at the contents
        if (a.action != ACT_UNUSED)
            for (int i = 0; i < bag_fill; i++)
                if (bag_slots[i] == a.value) occ++;
        if (a.action == ACT_INSERT) begin
            // full store refuses, but still reports the copies it holds
            if (bag_fill >= CAPACITY) begin
                r.rejected = 1'b1;
            end else begin
                bag_slots[bag_fill] = a.value;
                bag_fill++;
            end
        end else if (a.action == ACT_REMOVE) begin
            // keep the first (occ - cut) copies, drop the trailing ones, close gaps
            cut  = (int'(a.limit) < occ) ? int'(a.limit) : occ;
            keep = occ - cut;
            seen = 0;
            w    = 0;
            for (int i = 0; i < bag_fill; i++) begin
                if (bag_slots[i] == a.value) begin
                    seen++;
                    if (seen > keep) continue;
                end
                bag_slots[w] = bag_slots[i];
                w++;
            end
            bag_fill = w;
        end
        r.found       = (occ != 0);
        r.occurrences = clip7(occ);
        r.removed     = clip7(cut);
        r.size_now    = clip7(bag_fill);
        r.empty_res   = (bag_fill == 0);
        return r;
    endfunction

    // Idle cycles before the next beat; every fourth window of 150 beats runs flat out.
    function automatic int draw_gap(input int idx);
        if ((idx / 150) % 4 == 1) return 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic queue_action(input logic [1:0] act, input logic [DATA_W-1:0] val,
                                input logic [FIELD_W-1:0] lim);
        t_bag_action a;
        a.action = act;
        a.value  = val;
        a.limit  = lim;
        actions_to_send.push_back(a);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Driver: presents queued actions, idles a random number of cycles between
    // beats, holds the payload steady while stalled. The expected reply is
    // computed at the very edge the block takes the beat.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : tx_driver
        int gap;
        int tx_gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_action   <= ACT_INSERT;
            i_value    <= '0;
            i_limit    <= '0;
            n_accepted <= 0;
            tx_gap     = 0;
        end else if (i_in_valid && !o_in_stall) begin
            replies_due.push_back(apply_bag_action({i_action, i_value, i_limit}));
            n_accepted <= n_accepted + 1;
            gap = draw_gap(n_accepted);
            if (gap == 0 && actions_to_send.size() != 0) begin
                // back-to-back: valid stays high, only the payload moves
                {i_action, i_value, i_limit} <= actions_to_send.pop_front();
            end else begin
                // the cycle with valid low right after this edge is the first idle one
                i_in_valid <= 1'b0;
                tx_gap = (gap > 0) ? gap - 1 : 0;
            end
        end else if (!i_in_valid) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (actions_to_send.size() != 0) begin
                {i_action, i_value, i_limit} <= actions_to_send.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: after each taken beat, stall for a random count.
    // The long hold-off below is ORed in.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_stall
        int g;
        int rx_gap;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_gap      = 0;
        end else begin
            if (o_out_valid && !i_out_stall) g = draw_gap(n_replies + 75);
            else g = rx_gap;
            if (g > 0) begin
                i_out_stall <= 1'b1;
                rx_gap = g - 1;
            end else begin
                i_out_stall <= hold_on;
                rx_gap = 0;
            end
        end
    end

    // One long hold-off mid-run; the sender keeps offering so the block backs up
    // and has to stall its input.
    always @(posedge i_clk) begin : rx_hold
        int hold_left;
        logic hold_done;
        if (!i_rst_n) begin
            hold_on   <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_on   <= 1'b1;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) hold_on <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every taken reply is matched against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_monitor
        t_bag_reply got;
        t_bag_reply want;
        if (!i_rst_n) begin
            n_replies <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            n_replies <= n_replies + 1;
            got = {o_found, o_occurrences, o_removed, o_size, o_empty_res, o_rejected};
            if (replies_due.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display({"%0t: unexpected reply found=%0b occ=%0d rem=%0d",
                              " size=%0d empty=%0b rej=%0b"},
                             $realtime, got.found, got.occurrences, got.removed,
                             got.size_now, got.empty_res, got.rejected);
            end else begin
                want = replies_due.pop_front();
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("%0t: reply %0d mismatch", $realtime, n_replies);
                        $display({"  expected found=%0b occ=%0d rem=%0d",
                                  " size=%0d empty=%0b rej=%0b"},
                                 want.found, want.occurrences, want.removed,
                                 want.size_now, want.empty_res, want.rejected);
                        $display({"  actual   found=%0b occ=%0d rem=%0d",
                                  " size=%0d empty=%0b rej=%0b"},
                                 got.found, got.occurrences, got.removed,
                                 got.size_now, got.empty_res, got.rejected);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial begin
        logic [DATA_W-1:0]  pool [8];
        logic [DATA_W-1:0]  val;
        logic [1:0]         act;
        logic [FIELD_W-1:0] lim;
        int                 queued;
        int                 phase_len;
        int                 roll;
        logic               grow;
        logic               first;

        i_rst_n   = 1'b0;
        n_errors  = 0;
        bag_fill  = 0;

        // Directed: empty-store corner cases, sign/extreme values, limit 0 and
        // limit above the count, trailing-copy removal, the unused code.
        queue_action(ACT_COUNT,  32'h0000_0000, 7'd0);
        queue_action(ACT_REMOVE, 32'h0000_0000, 7'd127);
        queue_action(ACT_UNUSED, 32'hFFFF_FFFF, 7'd127);
        queue_action(ACT_INSERT, 32'h8000_0000, 7'd127);
        queue_action(ACT_INSERT, 32'h7FFF_FFFF, 7'd0);
        queue_action(ACT_INSERT, 32'h0000_0000, 7'd64);
        queue_action(ACT_INSERT, 32'hFFFF_FFFF, 7'd1);
        queue_action(ACT_INSERT, 32'h8000_0000, 7'd0);
        queue_action(ACT_COUNT,  32'h8000_0000, 7'd127);
        queue_action(ACT_REMOVE, 32'h8000_0000, 7'd0);
        queue_action(ACT_REMOVE, 32'hFFFF_FFFF, 7'd1);
        queue_action(ACT_UNUSED, 32'h7FFF_FFFF, 7'd127);
        queue_action(ACT_INSERT, 32'h0000_0005, 7'd0);
        queue_action(ACT_INSERT, 32'h0000_0009, 7'd0);
        queue_action(ACT_INSERT, 32'h0000_0005, 7'd0);
        queue_action(ACT_INSERT, 32'h0000_0009, 7'd0);
        queue_action(ACT_INSERT, 32'h0000_0005, 7'd0);
        queue_action(ACT_REMOVE, 32'h0000_0005, 7'd2);
        queue_action(ACT_COUNT,  32'h0000_0005, 7'd0);
        queue_action(ACT_REMOVE, 32'h0000_0009, 7'd64);
        queue_action(ACT_REMOVE, 32'h8000_0000, 7'd127);
        queue_action(ACT_COUNT,  32'h7FFF_FFFF, 7'd0);

        // Random: alternating grow and drain phases over a small value pool so
        // duplicates pile up; grow phases run the store into full (rejected
        // inserts), drain phases thin it out again with mixed limits.
        queued = 0;
        grow   = 1'b1;
        first  = 1'b1;
        while (queued < RANDOM_BEATS) begin
            foreach (pool[k]) begin
                case ($urandom_range(0, 4))
                    0:       pool[k] = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    1:       pool[k] = $urandom_range(0, 7);
                    default: pool[k] = $urandom;
                endcase
            end
            phase_len = first ? 100 : $urandom_range(30, 120);
            first = 1'b0;
            for (int n = 0; n < phase_len && queued < RANDOM_BEATS; n++) begin
                roll = $urandom_range(0, 99);
                if (grow)
                    act = roll < 80 ? ACT_INSERT : roll < 91 ? ACT_COUNT :
                          roll < 96 ? ACT_REMOVE : ACT_UNUSED;
                else
                    act = roll < 55 ? ACT_REMOVE : roll < 80 ? ACT_COUNT :
                          roll < 95 ? ACT_INSERT : ACT_UNUSED;
                // mostly pool values for collisions, sometimes anything at all
                if ($urandom_range(0, 99) < 85)
                    val = pool[$urandom_range(0, grow ? 7 : 3)];
                else
                    val = $urandom;
                if ($urandom_range(0, 99) < 65)
                    lim = FIELD_W'($urandom_range(0, 4));
                else
                    lim = FIELD_W'($urandom_range(0, 127));
                queue_action(act, val, lim);
                queued++;
            end
            grow = ~grow;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything sent, everything answered, then a tail for stray replies
        while (actions_to_send.size() != 0 || i_in_valid) @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (2 * CAPACITY + 8) @(posedge i_clk);

        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
